// File: hdl/distance_vector_route_update_top_assert.svh
// Assertion macros used by the checker module of the route update block.
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_TOP_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DVRU_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DVRU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/dvru_pkg.sv
// Types and constants of the distance-vector route update block.
package dvru_pkg;

    localparam int unsigned ROUTER_W = 4;
    localparam int unsigned DEST_W   = 4;
    localparam int unsigned DIST_W   = 8;

    localparam logic [DIST_W-1:0] INFINITY_RESET = 8'd16;

    typedef struct packed {
        logic                valid;
        logic [ROUTER_W-1:0] next_hop;
        logic [DIST_W-1:0]   distance;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

endpackage

// File: hdl/dvru_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dvru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/distance_vector_route_update_top.sv
// Distance-vector route update: routing tables in one RAM, updated by read-modify-write.
//
// Each request on the input channel is one advertised route (receiver, sender,
// destination, advertised distance). The block offers the advertised distance
// plus one, saturated at the infinity metric, to the receiver's table entry for
// the destination and returns one result: the distance and next hop held after
// the update, plus changed and added flags. Out-of-range indexes leave the
// table alone and return an all-zero result.
// The infinity metric is written through the configuration channel, which is
// always ready; it resets to 16.
// The table entry is read at the accepting clock edge into the update stage,
// which updates and writes back the entry and passes the result to the result
// register. A new request is taken every cycle while the output does not stall; a
// write to the entry that the next request reads is forwarded to it.
// After reset the block clears the table, one entry per cycle, with the input
// ready low. When the receiver stalls the result is held, the update stage holds
// its item, and the input is taken again once the result register drains.
module distance_vector_route_update_top
    import dvru_pkg::*;
#(
    parameter int ROUTERS      = 16,
    parameter int DESTINATIONS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ROUTER_W-1:0] i_receiver,
    input  logic [ROUTER_W-1:0] i_sender,
    input  logic [DEST_W-1:0]   i_destination,
    input  logic [DIST_W-1:0]   i_advertised_distance,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [DIST_W-1:0]   o_new_distance,
    output logic [ROUTER_W-1:0] o_next_hop,
    output logic                o_changed,
    output logic                o_added,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [DIST_W-1:0]   i_cfg_data
);

    localparam int DEPTH  = ROUTERS * DESTINATIONS;
    localparam int ADDR_W = $clog2(DEPTH);

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [DIST_W-1:0]   r_infinity;

    logic                r_s1_valid;
    logic                r_s1_in_range;
    logic [ADDR_W-1:0]   r_s1_addr;
    logic [ROUTER_W-1:0] r_s1_sender;
    logic [DIST_W-1:0]   r_s1_metric;
    logic                r_fwd_valid;
    t_entry              r_fwd_word;

    logic                r_out_valid;
    logic [DIST_W-1:0]   r_out_distance;
    logic [ROUTER_W-1:0] r_out_next_hop;
    logic                r_out_changed;
    logic                r_out_added;

    logic                clr_active;
    logic                clr_done;
    logic                in_accept;
    logic                s1_go;
    logic                in_range;
    logic [ADDR_W-1:0]   in_addr;
    logic [DIST_W:0]     metric_sum;
    logic [DIST_W-1:0]   metric;
    t_entry              old_entry;
    t_entry              new_entry;
    logic                upd_changed;
    logic                upd_added;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    t_entry              ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (clr_done) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: n_state = ST_RUN;
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_CLEAR: clr_active = 1'b1;
            ST_RUN:   clr_active = 1'b0;
            default:  clr_active = 1'b1;
        endcase
    end

    assign clr_done   = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !clr_active && (!r_s1_valid || s1_go);
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign in_range = (32'(i_receiver) < ROUTERS) && (32'(i_destination) < DESTINATIONS);
    assign in_addr  = ADDR_W'(32'(i_receiver) * DESTINATIONS + 32'(i_destination));

    assign metric_sum = {1'b0, i_advertised_distance} + (DIST_W+1)'(1);
    assign metric = (metric_sum > {1'b0, r_infinity}) ? r_infinity : metric_sum[DIST_W-1:0];

    always_comb begin
        old_entry   = r_fwd_valid ? r_fwd_word : t_entry'(ram_rdata);
        new_entry   = old_entry;
        upd_changed = 1'b0;
        upd_added   = 1'b0;
        priority if (!old_entry.valid) begin
            new_entry   = '{valid: 1'b1, next_hop: r_s1_sender, distance: r_s1_metric};
            upd_changed = 1'b1;
            upd_added   = 1'b1;
        end else if (old_entry.next_hop == r_s1_sender) begin
            new_entry.distance = r_s1_metric;
        end else if (old_entry.distance > r_s1_metric) begin
            new_entry   = '{valid: 1'b1, next_hop: r_s1_sender, distance: r_s1_metric};
            upd_changed = 1'b1;
        end else begin
            new_entry = old_entry;
        end
    end

    always_comb begin
        if (clr_active) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_go && r_s1_in_range;
            ram_waddr = r_s1_addr;
            ram_wdata = new_entry;
        end
    end

    dvru_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_infinity  <= INFINITY_RESET;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr_active && !clr_done) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cfg_valid) begin
                r_infinity <= i_cfg_data;
            end
            if (in_accept) begin
                r_s1_valid  <= 1'b1;
                r_fwd_valid <= ram_we && (ram_waddr == in_addr);
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_in_range <= in_range;
            r_s1_addr     <= in_addr;
            r_s1_sender   <= i_sender;
            r_s1_metric   <= metric;
            r_fwd_word    <= ram_wdata;
        end
        if (s1_go) begin
            if (r_s1_in_range) begin
                r_out_distance <= new_entry.distance;
                r_out_next_hop <= new_entry.next_hop;
                r_out_changed  <= upd_changed;
                r_out_added    <= upd_added;
            end else begin
                r_out_distance <= '0;
                r_out_next_hop <= '0;
                r_out_changed  <= 1'b0;
                r_out_added    <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_new_distance = r_out_distance;
    assign o_next_hop     = r_out_next_hop;
    assign o_changed      = r_out_changed;
    assign o_added        = r_out_added;

endmodule

// File: hdl/dvru_checker.sv
// Port-level checker of the route update block and its bind to the top level.
`include "distance_vector_route_update_top_assert.svh"

module dvru_checker
    import dvru_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [DIST_W-1:0]   o_new_distance,
    input logic [ROUTER_W-1:0] o_next_hop,
    input logic                o_changed,
    input logic                o_added,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready
);

    `DVRU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_new_distance) && $stable(o_next_hop),
        "Stalled result was dropped or changed.")

    `DVRU_ASSERT_NOW(a_added_changed, i_clk, i_rst_n, o_out_valid && o_added, o_changed,
        "A newly added entry must be reported as changed.")

    `DVRU_ASSERT_NOW(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready,
        "Configuration request was not taken at once.")

    `DVRU_ASSERT_NEXT(a_no_result_idle, i_clk, i_rst_n,
        !o_out_valid && !o_in_ready && !i_cfg_valid && $past(!o_in_ready),
        !o_out_valid || $past(o_out_valid),
        "Result appeared without a request in flight.")

endmodule

bind distance_vector_route_update_top dvru_checker u_dvru_checker (.*);

// File: sim/tb.sv
// Self-checking testbench for the distance-vector route update block with its scoreboard.
`timescale 1ns / 1ps

module tb;
    import dvru_pkg::*;

    localparam int TABLE_DEPTH = 1 << (ROUTER_W + DEST_W);
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTED = 20;
    localparam int PHASE_ITEMS = 175;
    localparam int RANDOM_PHASES = 6;

    typedef struct packed {
        bit [ROUTER_W-1:0] receiver;
        bit [ROUTER_W-1:0] sender;
        bit [DEST_W-1:0]   destination;
        bit [DIST_W-1:0]   advertised;
    } t_route;

    typedef struct packed {
        logic [DIST_W-1:0]   distance;
        logic [ROUTER_W-1:0] next_hop;
        logic                changed;
        logic                added;
    } t_route_result;

    class route_table_sb;
        bit                valid_q[TABLE_DEPTH];
        bit [DIST_W-1:0]   dist_q[TABLE_DEPTH];
        bit [ROUTER_W-1:0] hop_q[TABLE_DEPTH];
        bit [DIST_W-1:0]   infinity;
        t_route_result     expected_q[$];
        int errors;
        int requests;
        int results;
        int n_added;
        int n_replaced;
        int n_refreshed;
        int n_kept;

        function new();
            infinity = INFINITY_RESET;
        endfunction

        function void set_infinity(bit [DIST_W-1:0] value);
            infinity = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(t_route r);
            bit [DIST_W:0]   offered;
            int              idx;
            t_route_result   res;
            offered = {1'b0, r.advertised} + (DIST_W+1)'(1);
            if (offered > {1'b0, infinity}) begin
                offered = {1'b0, infinity};
            end
            idx = int'({r.receiver, r.destination});
            res.changed = 1'b0;
            res.added = 1'b0;
            if (!valid_q[idx]) begin
                valid_q[idx] = 1'b1;
                dist_q[idx] = offered[DIST_W-1:0];
                hop_q[idx] = r.sender;
                res.changed = 1'b1;
                res.added = 1'b1;
                n_added++;
            end else if (hop_q[idx] == r.sender) begin
                dist_q[idx] = offered[DIST_W-1:0];
                n_refreshed++;
            end else if ({1'b0, dist_q[idx]} > offered) begin
                dist_q[idx] = offered[DIST_W-1:0];
                hop_q[idx] = r.sender;
                res.changed = 1'b1;
                n_replaced++;
            end else begin
                n_kept++;
            end
            res.distance = dist_q[idx];
            res.next_hop = hop_q[idx];
            expected_q = {expected_q, res};
            requests++;
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
        endtask

        task check_result(t_route_result got);
            t_route_result want;
            results++;
            if (expected_q.size() == 0) begin
                report_mismatch("result with no pending request");
            end else begin
                want = expected_q.pop_front();
                if (got.distance !== want.distance) begin
                    report_mismatch($sformatf("distance got %0d expected %0d",
                                              got.distance, want.distance));
                end
                if (got.next_hop !== want.next_hop) begin
                    report_mismatch($sformatf("next_hop got %0d expected %0d",
                                              got.next_hop, want.next_hop));
                end
                if (got.changed !== want.changed) begin
                    report_mismatch($sformatf("changed got %b expected %b",
                                              got.changed, want.changed));
                end
                if (got.added !== want.added) begin
                    report_mismatch($sformatf("added got %b expected %b",
                                              got.added, want.added));
                end
            end
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                o_in_ready;
    logic [ROUTER_W-1:0] receiver = '0;
    logic [ROUTER_W-1:0] sender = '0;
    logic [DEST_W-1:0]   destination = '0;
    logic [DIST_W-1:0]   advertised = '0;
    logic                o_out_valid;
    logic                out_ready = 1'b0;
    logic [DIST_W-1:0]   o_new_distance;
    logic [ROUTER_W-1:0] o_next_hop;
    logic                o_changed;
    logic                o_added;
    logic                cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [DIST_W-1:0]   cfg_data = '0;

    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            cycle_count = 0;
    int            infinity_writes = 0;
    route_table_sb sb = new();

    distance_vector_route_update_top DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (in_valid),
        .o_in_ready            (o_in_ready),
        .i_receiver            (receiver),
        .i_sender              (sender),
        .i_destination         (destination),
        .i_advertised_distance (advertised),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (out_ready),
        .o_new_distance        (o_new_distance),
        .o_next_hop            (o_next_hop),
        .o_changed             (o_changed),
        .o_added               (o_added),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_data            (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending.",
                     cycle_count, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            sb.check_result('{o_new_distance, o_next_hop, o_changed, o_added});
        end
        out_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
    end

    task automatic push_route(input t_route r);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        receiver <= r.receiver;
        sender <= r.sender;
        destination <= r.destination;
        advertised <= r.advertised;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(r);
    endtask

    task automatic set_infinity(input bit [DIST_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_infinity(value);
        infinity_writes++;
    endtask

    function automatic t_route next_random_route(input t_route prev);
        t_route r;
        int     sel;
        int     top;
        sel = int'($urandom_range(99));
        top = (sb.infinity > 1) ? int'(sb.infinity) : 1;
        r.receiver = ROUTER_W'($urandom_range(15));
        r.sender = ROUTER_W'($urandom_range(15));
        r.destination = DEST_W'($urandom_range(15));
        r.advertised = DIST_W'($urandom_range(255));
        if (sel < 15) begin
            return r;
        end else if (sel < 30) begin
            r.sender = r.receiver;
            r.destination = r.receiver;
            r.advertised = '0;
        end else if (sel < 50) begin
            r.receiver = prev.receiver;
            r.destination = prev.destination;
            r.sender = ROUTER_W'((int'(prev.receiver) + int'($urandom_range(1, 3))) % 16);
            r.advertised = DIST_W'($urandom_range(top));
        end else begin
            r.sender = ROUTER_W'((int'(r.receiver) +
                                  (($urandom_range(1) != 0) ? 1 : 15)) % 16);
            r.advertised = DIST_W'($urandom_range(top));
        end
        return r;
    endfunction

    initial begin
        t_route r;
        int     phase;
        int     n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 29;
        recv_idle_pct = 54;

        push_route('{4'd3, 4'd3, 4'd3, 8'd0});
        push_route('{4'd3, 4'd5, 4'd3, 8'd0});
        push_route('{4'd0, 4'd1, 4'd7, 8'd4});
        push_route('{4'd0, 4'd2, 4'd7, 8'd2});
        push_route('{4'd0, 4'd1, 4'd7, 8'd1});
        push_route('{4'd0, 4'd1, 4'd7, 8'd9});
        push_route('{4'd0, 4'd2, 4'd7, 8'd12});
        push_route('{4'd0, 4'd4, 4'd7, 8'd255});
        push_route('{4'd15, 4'd15, 4'd15, 8'd255});
        push_route('{4'd15, 4'd0, 4'd15, 8'd0});
        push_route('{4'd15, 4'd0, 4'd15, 8'd15});
        push_route('{4'd0, 4'd0, 4'd0, 8'd0});
        push_route('{4'd0, 4'd0, 4'd0, 8'd255});
        push_route('{4'd15, 4'd15, 4'd0, 8'd14});
        set_infinity(8'd255);
        push_route('{4'd1, 4'd2, 4'd3, 8'd254});
        push_route('{4'd1, 4'd2, 4'd3, 8'd255});
        push_route('{4'd1, 4'd4, 4'd3, 8'd253});
        set_infinity(8'd0);
        push_route('{4'd2, 4'd2, 4'd2, 8'd0});
        push_route('{4'd2, 4'd3, 4'd2, 8'd100});
        push_route('{4'd0, 4'd9, 4'd7, 8'd0});
        set_infinity(8'd1);
        push_route('{4'd2, 4'd3, 4'd2, 8'd0});
        push_route('{4'd2, 4'd2, 4'd2, 8'd200});
        push_route('{4'd4, 4'd6, 4'd8, 8'd255});
        set_infinity(8'd2);
        push_route('{4'd4, 4'd7, 4'd8, 8'd0});
        push_route('{4'd4, 4'd6, 4'd8, 8'd1});

        r = '0;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            unique case (phase)
                0: set_infinity(8'd255);
                1: set_infinity(8'd2);
                2: set_infinity(DIST_W'($urandom_range(3, 254)));
                3: set_infinity(INFINITY_RESET);
                4: set_infinity(8'd0);
                default: set_infinity(DIST_W'($urandom_range(2, 255)));
            endcase
            if (phase < 2) begin
                send_idle_pct = 29;
                recv_idle_pct = 54;
            end else if (phase < 4) begin
                send_idle_pct = 54;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                r = next_random_route(r);
                push_route(r);
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d advertisements under %0d infinity settings: %0d added, %0d replaced,",
                 sb.requests, infinity_writes + 1, sb.n_added, sb.n_replaced);
        $display("%0d same-hop refreshes, %0d offers kept; %0d results checked, %0d mismatches.",
                 sb.n_refreshed, sb.n_kept, sb.results, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
